// ===== rtl/core/mei_pkg.sv =====
// shared types, constants and helpers for the mandelbrot escape iterator
package mei_pkg;

    localparam int WORD_W  = 40;
    localparam int FRAC_W  = 24;
    localparam int HALF_W  = 20;
    localparam int PROD_W  = WORD_W + HALF_W;
    localparam int ACC_W   = 2 * WORD_W;
    localparam int DIFF_W  = 13;
    localparam int COORD_W = 10;
    localparam int CENT_W  = 12;
    localparam int ITER_W  = 8;
    localparam int BOUND_W = 10;
    localparam int STEP_W  = 24;
    localparam int IDX_W   = 3;
    localparam int IN_W    = 24;

    localparam logic signed [WORD_W-1:0] WMAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] WMIN = {1'b1, {(WORD_W-1){1'b0}}};

    localparam logic [ITER_W-1:0]  MAX_ITER_RST   = 8'd255;
    localparam logic [BOUND_W-1:0] ESCAPE_R2_RST  = 10'd100;
    localparam logic [STEP_W-1:0]  PIXEL_STEP_RST = 24'd55924;
    localparam int                 COL_OFFSET     = 400;

    localparam logic [IDX_W-1:0] CFG_MAX_ITER   = 3'd0;
    localparam logic [IDX_W-1:0] CFG_ESCAPE_R2  = 3'd1;
    localparam logic [IDX_W-1:0] CFG_CENTER_COL = 3'd2;
    localparam logic [IDX_W-1:0] CFG_CENTER_ROW = 3'd3;
    localparam logic [IDX_W-1:0] CFG_PIXEL_STEP = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CRE,
        S_CRE_W,
        S_CIM,
        S_CIM_W,
        S_SQR,
        S_SQR_W,
        S_SQI,
        S_SQI_W,
        S_CHK,
        S_PRD,
        S_PRD_W,
        S_UPD,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        M_IDLE,
        M_HI,
        M_LO,
        M_ACC,
        M_FIN
    } t_mul_state;

    typedef struct packed {
        logic                     start;
        logic signed [WORD_W-1:0] a;
        logic signed [WORD_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic                     done;
        logic signed [WORD_W-1:0] result;
    } t_mul_rsp;

    // clamp a 42-bit signed sum to the 40-bit word range
    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [WORD_W+1:0] v);
        logic ovf_pos;
        logic ovf_neg;
        ovf_pos = !v[WORD_W+1] && (v[WORD_W:WORD_W-1] != 2'b00);
        ovf_neg = v[WORD_W+1] && (v[WORD_W:WORD_W-1] != 2'b11);
        if (ovf_pos) begin
            return WMAX;
        end else if (ovf_neg) begin
            return WMIN;
        end else begin
            return v[WORD_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/core/mei_fxmul.sv =====
// shared fixed-point multiplier, 40x20 bits per pass, two passes per product
module mei_fxmul
    import mei_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    t_mul_state r_state;
    t_mul_state n_state;

    logic [WORD_W-1:0] r_ua;
    logic [WORD_W-1:0] r_ub;
    logic              r_neg;
    logic [PROD_W-1:0] r_prod;
    logic [ACC_W-1:0]  r_acc;

    logic [WORD_W-1:0]        mag_a;
    logic [WORD_W-1:0]        mag_b;
    logic [ACC_W-FRAC_W-1:0]  quo;
    logic                     ovf;
    logic [WORD_W-1:0]        quo_w;

    assign mag_a = i_req.a[WORD_W-1] ? (~i_req.a + 1'b1) : i_req.a;
    assign mag_b = i_req.b[WORD_W-1] ? (~i_req.b + 1'b1) : i_req.b;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            M_IDLE: begin
                if (i_req.start) begin
                    n_state = M_HI;
                end
            end
            M_HI:   n_state = M_LO;
            M_LO:   n_state = M_ACC;
            M_ACC:  n_state = M_FIN;
            M_FIN:  n_state = M_IDLE;
            default: n_state = M_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            M_IDLE: begin
                if (i_req.start) begin
                    r_ua  <= mag_a;
                    r_ub  <= mag_b;
                    r_neg <= i_req.a[WORD_W-1] ^ i_req.b[WORD_W-1];
                end
            end
            M_HI: begin
                r_prod <= r_ua * r_ub[WORD_W-1:HALF_W];
            end
            M_LO: begin
                r_acc  <= {r_prod, {HALF_W{1'b0}}};
                r_prod <= r_ua * r_ub[HALF_W-1:0];
            end
            M_ACC: begin
                r_acc <= r_acc + {{(ACC_W-PROD_W){1'b0}}, r_prod};
            end
            default: ;
        endcase
    end

    // truncate magnitude, apply sign, clamp
    assign quo   = r_acc[ACC_W-1:FRAC_W];
    assign ovf   = |quo[ACC_W-FRAC_W-1:WORD_W-1];
    assign quo_w = quo[WORD_W-1:0];

    always_comb begin
        o_rsp.done = (r_state == M_FIN);
        if (ovf) begin
            o_rsp.result = r_neg ? WMIN : WMAX;
        end else if (r_neg) begin
            o_rsp.result = ~quo_w + 1'b1;
        end else begin
            o_rsp.result = quo_w;
        end
    end

endmodule

// ===== rtl/core/mandelbrot_escape_iterator_unit.sv =====
// Mandelbrot escape-time iterator: one pixel position in, one iteration count out.
// Every multiplication, including the pixel-to-plane mapping, goes through one
// shared 40x20-bit multiplier, which builds each 40x40 product from partial
// products; an iteration uses three products plus a check step and an update
// step. The input side is not ready while a pixel is in work; a finished count
// waits in an output register, so the next pixel can be taken while the count
// is still unread. Configuration writes are always ready and take effect at
// once; write them only between pixels.
module mandelbrot_escape_iterator_unit
    import mei_pkg::*;
#(
    parameter int COLS = 1024,
    parameter int ROWS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [IN_W-1:0]    s_axis_tdata,   // column[9:0], row[19:10], zero pad
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [ITER_W-1:0]  m_axis_tdata,   // iterations[7:0]
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [IDX_W-1:0]   i_cfg_index,
    input  logic [STEP_W-1:0]  i_cfg_data
);

    localparam int CenterColRst = ((COLS + COL_OFFSET) / 2) % 4096;
    localparam int CenterRowRst = (ROWS / 2) % 4096;

    t_state r_state;
    t_state n_state;

    logic [ITER_W-1:0]  r_max_iter;
    logic [BOUND_W-1:0] r_escape_r2;
    logic [CENT_W-1:0]  r_center_col;
    logic [CENT_W-1:0]  r_center_row;
    logic [STEP_W-1:0]  r_pixel_step;

    logic [COORD_W-1:0]       r_col;
    logic [COORD_W-1:0]       r_row;
    logic signed [WORD_W-1:0] r_c_re;
    logic signed [WORD_W-1:0] r_c_im;
    logic signed [WORD_W-1:0] r_re;
    logic signed [WORD_W-1:0] r_im;
    logic signed [WORD_W-1:0] r_sq_re;
    logic signed [WORD_W-1:0] r_sq_im;
    logic signed [WORD_W-1:0] r_rim;
    logic [ITER_W-1:0]        r_n;
    logic                     r_out_valid;
    logic [ITER_W-1:0]        r_out_data;

    t_mul_req mul_req;
    t_mul_rsp mul_rsp;

    logic signed [DIFF_W-1:0] diff_col;
    logic signed [DIFF_W-1:0] diff_row;
    logic signed [WORD_W-1:0] fx_col;
    logic signed [WORD_W-1:0] fx_row;
    logic signed [WORD_W-1:0] fx_step;
    logic [WORD_W-1:0]        mag2;
    logic [WORD_W-1:0]        bound;
    logic                     stop;
    logic                     out_free;
    logic                     in_acc;
    logic signed [WORD_W+1:0] sum_re;
    logic signed [WORD_W+1:0] sum_im;

    mei_fxmul u_fxmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    // plane mapping operands, pixel offset placed at the integer position
    assign diff_col = $signed({3'b000, r_col}) - $signed({1'b0, r_center_col});
    assign diff_row = $signed({3'b000, r_row}) - $signed({1'b0, r_center_row});
    assign fx_col   = {{(WORD_W-DIFF_W-FRAC_W){diff_col[DIFF_W-1]}}, diff_col, {FRAC_W{1'b0}}};
    assign fx_row   = {{(WORD_W-DIFF_W-FRAC_W){diff_row[DIFF_W-1]}}, diff_row, {FRAC_W{1'b0}}};
    assign fx_step  = {{(WORD_W-STEP_W){1'b0}}, r_pixel_step};

    // squares are never negative, so the 40-bit sum cannot wrap
    assign mag2  = r_sq_re + r_sq_im;
    assign bound = {{(WORD_W-BOUND_W-FRAC_W){1'b0}}, r_escape_r2, {FRAC_W{1'b0}}};
    assign stop  = (r_n >= r_max_iter) || (r_escape_r2 == '0)
                 || ((r_n != '0) && (mag2 >= bound));

    assign sum_re = {{2{r_sq_re[WORD_W-1]}}, r_sq_re} - {{2{r_sq_im[WORD_W-1]}}, r_sq_im}
                  + {{2{r_c_re[WORD_W-1]}}, r_c_re};
    assign sum_im = {r_rim[WORD_W-1], r_rim, 1'b0} + {{2{r_c_im[WORD_W-1]}}, r_c_im};

    assign out_free = !r_out_valid || m_axis_tready;
    assign in_acc   = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (s_axis_tvalid) n_state = S_CRE;
            S_CRE:   n_state = S_CRE_W;
            S_CRE_W: if (mul_rsp.done) n_state = S_CIM;
            S_CIM:   n_state = S_CIM_W;
            S_CIM_W: if (mul_rsp.done) n_state = S_SQR;
            S_SQR:   n_state = S_SQR_W;
            S_SQR_W: if (mul_rsp.done) n_state = S_SQI;
            S_SQI:   n_state = S_SQI_W;
            S_SQI_W: if (mul_rsp.done) n_state = S_CHK;
            S_CHK:   n_state = stop ? S_DONE : S_PRD;
            S_PRD:   n_state = S_PRD_W;
            S_PRD_W: if (mul_rsp.done) n_state = S_UPD;
            S_UPD:   n_state = S_SQR;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        mul_req.start = 1'b0;
        mul_req.a     = r_re;
        mul_req.b     = r_re;
        unique case (r_state)
            S_IDLE: s_axis_tready = 1'b1;
            S_CRE, S_CRE_W: begin
                mul_req.start = (r_state == S_CRE);
                mul_req.a     = fx_col;
                mul_req.b     = fx_step;
            end
            S_CIM, S_CIM_W: begin
                mul_req.start = (r_state == S_CIM);
                mul_req.a     = fx_row;
                mul_req.b     = fx_step;
            end
            S_SQR, S_SQR_W: begin
                mul_req.start = (r_state == S_SQR);
            end
            S_SQI, S_SQI_W: begin
                mul_req.start = (r_state == S_SQI);
                mul_req.a     = r_im;
                mul_req.b     = r_im;
            end
            S_PRD, S_PRD_W: begin
                mul_req.start = (r_state == S_PRD);
                mul_req.b     = r_im;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_max_iter   <= MAX_ITER_RST;
            r_escape_r2  <= ESCAPE_R2_RST;
            r_center_col <= CENT_W'(CenterColRst);
            r_center_row <= CENT_W'(CenterRowRst);
            r_pixel_step <= PIXEL_STEP_RST;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_MAX_ITER:   r_max_iter   <= i_cfg_data[ITER_W-1:0];
                    CFG_ESCAPE_R2:  r_escape_r2  <= i_cfg_data[BOUND_W-1:0];
                    CFG_CENTER_COL: r_center_col <= i_cfg_data[CENT_W-1:0];
                    CFG_CENTER_ROW: r_center_row <= i_cfg_data[CENT_W-1:0];
                    CFG_PIXEL_STEP: r_pixel_step <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_col <= s_axis_tdata[COORD_W-1:0];
            r_row <= s_axis_tdata[2*COORD_W-1:COORD_W];
            r_n   <= '0;
        end
        case (r_state)
            S_CRE_W: begin
                if (mul_rsp.done) begin
                    r_c_re <= mul_rsp.result;
                    r_re   <= mul_rsp.result;
                end
            end
            S_CIM_W: begin
                if (mul_rsp.done) begin
                    r_c_im <= mul_rsp.result;
                    r_im   <= mul_rsp.result;
                end
            end
            S_SQR_W: if (mul_rsp.done) r_sq_re <= mul_rsp.result;
            S_SQI_W: if (mul_rsp.done) r_sq_im <= mul_rsp.result;
            S_PRD_W: if (mul_rsp.done) r_rim <= mul_rsp.result;
            S_UPD: begin
                r_re <= sat_word(sum_re);
                r_im <= sat_word(sum_im);
                r_n  <= r_n + 1'b1;
            end
            S_DONE: if (out_free) r_out_data <= r_n;
            default: ;
        endcase
    end

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ===== rtl/core/mei_checker.sv =====
// port-level checks for the mandelbrot escape iterator, bound to the top level
module mei_checker
    import mei_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [ITER_W-1:0] m_axis_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // a pixel keeps the input side busy once it is accepted
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready)
        else $error("input ready too soon after a transaction");

    // a new result only comes out of a busy period
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared while idle");

endmodule

bind mandelbrot_escape_iterator_unit mei_checker u_mei_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/tb_top.sv =====
// self-checking testbench for the escape iterator, counts checked against a bit-exact predictor
`timescale 1ns / 1ps

module tb_top;
    import mei_pkg::*;

    localparam int COLS            = 1024;
    localparam int ROWS            = 1024;
    localparam int CYCLE_LIMIT     = 5000000;
    localparam int END_WAIT        = 4400;
    localparam int HOLD_CYCLES     = 1500;
    localparam int RANDOM_PHASES   = 18;
    localparam int ITEMS_PER_PHASE = 102;

    localparam longint WORD_HI = WMAX;
    localparam longint WORD_LO = WMIN;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [IN_W-1:0]    s_axis_tdata = '0;    // column[9:0], row[19:10], zero pad
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b1;
    logic [ITER_W-1:0]  m_axis_tdata;         // iterations[7:0]
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [IDX_W-1:0]   i_cfg_index = '0;
    logic [STEP_W-1:0]  i_cfg_data = '0;

    logic [ITER_W-1:0]  model_max_iter   = MAX_ITER_RST;
    logic [BOUND_W-1:0] model_escape_r2  = ESCAPE_R2_RST;
    logic [CENT_W-1:0]  model_center_col = CENT_W'((COLS + COL_OFFSET) / 2);
    logic [CENT_W-1:0]  model_center_row = CENT_W'(ROWS / 2);
    logic [STEP_W-1:0]  model_pixel_step = PIXEL_STEP_RST;

    logic [ITER_W-1:0]  pending_counts[$];
    logic [ITER_W-1:0]  oldest_count;
    int                 error_count = 0;
    int                 cycle_count = 0;
    int                 burst_max = 4;
    int                 gap_max = 3;
    int                 burst_left = 1;
    int                 ready_pct = 60;
    int                 hold_req = 0;
    int                 hold_left = 0;

    mandelbrot_escape_iterator_unit #(
        .COLS(COLS),
        .ROWS(ROWS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic longint clamp_word(input longint v);
        if (v > WORD_HI) begin
            return WORD_HI;
        end else if (v < WORD_LO) begin
            return WORD_LO;
        end
        return v;
    endfunction

    // q15.24 product: magnitudes multiplied exactly, truncated, signed, saturated
    function automatic longint fx_mul(input longint a, input longint b);
        logic         neg;
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [63:0]  mag;
        logic [127:0] prod;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? 64'(-a) : 64'(a);
        ub = (b < 0) ? 64'(-b) : 64'(b);
        prod = {64'd0, ua} * {64'd0, ub};
        mag = prod[FRAC_W +: 64];
        if (mag > 64'(WORD_HI)) begin
            mag = 64'(WORD_HI) + 64'(neg);
        end
        if (neg) begin
            return (mag > 64'(WORD_HI)) ? WORD_LO : -longint'(mag);
        end
        return longint'(mag);
    endfunction

    function automatic logic [ITER_W-1:0] escape_count(input logic [COORD_W-1:0] col,
                                                       input logic [COORD_W-1:0] row);
        longint c_re;
        longint c_im;
        longint z_re;
        longint z_im;
        longint sq_re;
        longint sq_im;
        longint prod_ri;
        longint mag2;
        longint limit_r2;
        int     n;
        c_re = (longint'(col) - longint'(model_center_col)) * longint'(model_pixel_step);
        c_im = (longint'(row) - longint'(model_center_row)) * longint'(model_pixel_step);
        z_re = c_re;
        z_im = c_im;
        limit_r2 = longint'(model_escape_r2) << FRAC_W;
        mag2 = 0;
        n = 0;
        while (n < model_max_iter && mag2 < limit_r2) begin
            sq_re = fx_mul(z_re, z_re);
            sq_im = fx_mul(z_im, z_im);
            prod_ri = fx_mul(z_re, z_im);
            z_re = clamp_word(sq_re - sq_im + c_re);
            z_im = clamp_word(2 * prod_ri + c_im);
            mag2 = clamp_word(fx_mul(z_re, z_re) + fx_mul(z_im, z_im));
            n++;
        end
        return ITER_W'(n);
    endfunction

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(1, 100) <= ready_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_counts.size() == 0) begin
                $display("%0t: unexpected count, expected none, actual %0d",
                         $time, m_axis_tdata);
                error_count++;
            end else begin
                oldest_count = pending_counts.pop_front();
                if (m_axis_tdata !== oldest_count) begin
                    $display("%0t: iterations mismatch, expected %0d, actual %0d",
                             $time, oldest_count, m_axis_tdata);
                    error_count++;
                end
            end
        end
    end

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [STEP_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_MAX_ITER:   model_max_iter   = value[ITER_W-1:0];
            CFG_ESCAPE_R2:  model_escape_r2  = value[BOUND_W-1:0];
            CFG_CENTER_COL: model_center_col = value[CENT_W-1:0];
            CFG_CENTER_ROW: model_center_row = value[CENT_W-1:0];
            CFG_PIXEL_STEP: model_pixel_step = value;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic program_frame(input logic [ITER_W-1:0] max_iter,
                                 input logic [BOUND_W-1:0] escape_r2,
                                 input logic [CENT_W-1:0] center_col,
                                 input logic [CENT_W-1:0] center_row,
                                 input logic [STEP_W-1:0] pixel_step);
        write_reg(CFG_MAX_ITER, STEP_W'(max_iter));
        write_reg(CFG_ESCAPE_R2, STEP_W'(escape_r2));
        write_reg(CFG_CENTER_COL, STEP_W'(center_col));
        write_reg(CFG_CENTER_ROW, STEP_W'(center_row));
        write_reg(CFG_PIXEL_STEP, pixel_step);
    endtask

    task automatic send_pixel(input int col, input int row);
        int gap;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_W - 2 * COORD_W){1'b0}}, COORD_W'(row), COORD_W'(col)};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_counts.push_back(escape_count(COORD_W'(col), COORD_W'(row)));
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, burst_max);
            gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            if (gap > 0) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    task automatic wait_results_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_counts.size() > 0) @(posedge i_clk);
    endtask

    task automatic test_reset_defaults();
        send_pixel(0, 0);
        send_pixel(1023, 1023);
        send_pixel(model_center_col, model_center_row);
        send_pixel(0, 1023);
        send_pixel(1023, 0);
        send_pixel(412, 512);
    endtask

    task automatic test_register_writes();
        int k;
        wait_results_drained();
        // unused indexes must leave every register alone
        for (k = CFG_PIXEL_STEP + 1; k < 2 ** IDX_W; k++) begin
            write_reg(IDX_W'(k), '1);
        end
        // upper data bits beyond each register width are dropped
        write_reg(CFG_MAX_ITER, 24'hABCD10);
        write_reg(CFG_ESCAPE_R2, 24'hFFF004);
        write_reg(CFG_CENTER_COL, 24'h5A5200);
        write_reg(CFG_CENTER_ROW, 24'hA5A1FF);
        write_reg(CFG_PIXEL_STEP, 24'h00DA74);
        send_pixel(512, 511);
        send_pixel(300, 700);
        send_pixel(1000, 20);
        send_pixel(450, 520);
    endtask

    task automatic test_zero_limits();
        wait_results_drained();
        write_reg(CFG_MAX_ITER, '0);
        send_pixel(512, 511);
        send_pixel(0, 0);
        wait_results_drained();
        write_reg(CFG_MAX_ITER, STEP_W'(MAX_ITER_RST));
        write_reg(CFG_ESCAPE_R2, '0);
        send_pixel(512, 511);
        send_pixel(1023, 1023);
    endtask

    task automatic test_field_extremes();
        wait_results_drained();
        // huge plane coordinates: squares saturate and count as escaped
        program_frame(MAX_ITER_RST, '1, '0, '1, '1);
        send_pixel(1023, 0);
        send_pixel(0, 1023);
        send_pixel(0, 0);
        wait_results_drained();
        // tiny step keeps every point near the origin
        program_frame(ITER_W'(20), BOUND_W'(1), CENT_W'(512), CENT_W'(512), STEP_W'(1));
        send_pixel(0, 0);
        send_pixel(1023, 1023);
        wait_results_drained();
        program_frame(ITER_W'(1), '1, '1, '0, '1);
        send_pixel(1023, 1023);
    endtask

    task automatic test_backpressure();
        int k;
        wait_results_drained();
        program_frame(ITER_W'(3), BOUND_W'(4), CENT_W'(512), CENT_W'(512), PIXEL_STEP_RST);
        ready_pct = 100;
        burst_max = 1000;
        gap_max = 0;
        @(posedge i_clk);
        hold_req = HOLD_CYCLES;
        for (k = 0; k < 12; k++) begin
            send_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
        end
        wait_results_drained();
    endtask

    task automatic test_random_frames();
        int                 phase;
        int                 k;
        int                 cc;
        int                 cr;
        int                 col;
        int                 row;
        logic               wide;
        logic [ITER_W-1:0]  mi;
        logic [BOUND_W-1:0] r2;
        logic [STEP_W-1:0]  st;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_results_drained();
            wide = (phase % 4 == 3) || (phase == 5);
            mi = (phase == 5) ? MAX_ITER_RST : ITER_W'($urandom_range(1, 24));
            case ($urandom_range(0, 3))
                0:       r2 = BOUND_W'(1);
                1:       r2 = '1;
                2:       r2 = BOUND_W'($urandom_range(1, 1023));
                default: r2 = BOUND_W'(4);
            endcase
            cc = wide ? $urandom_range(0, 4095) : $urandom_range(256, 768);
            cr = wide ? $urandom_range(0, 4095) : $urandom_range(256, 768);
            st = wide ? STEP_W'($urandom_range(1, 24'hFFFFFF))
                      : STEP_W'($urandom_range(14000, 220000));
            program_frame(mi, r2, CENT_W'(cc), CENT_W'(cr), st);
            case (phase % 3)
                0: begin
                    burst_max = 1000;
                    gap_max = 0;
                    ready_pct = 100;
                end
                1: begin
                    burst_max = 6;
                    gap_max = 6;
                    ready_pct = 70;
                end
                default: begin
                    burst_max = 3;
                    gap_max = 30;
                    ready_pct = 30;
                end
            endcase
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (wide || $urandom_range(0, 3) == 0) begin
                    col = $urandom_range(0, 1023);
                    row = $urandom_range(0, 1023);
                end else begin
                    // most pixels near the centre, where counts vary
                    col = cc + $urandom_range(0, 128) - 64;
                    row = cr + $urandom_range(0, 128) - 64;
                    col = (col < 0) ? 0 : (col > 1023) ? 1023 : col;
                    row = (row < 0) ? 0 : (row > 1023) ? 1023 : row;
                end
                send_pixel(col, row);
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_register_writes();
        test_zero_limits();
        test_field_extremes();
        test_backpressure();
        test_random_frames();
        wait_results_drained();
        repeat (END_WAIT) @(posedge i_clk);
        if (error_count == 0 && pending_counts.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/mei_pkg.sv
rtl/core/mei_fxmul.sv
rtl/core/mandelbrot_escape_iterator_unit.sv
rtl/core/mei_checker.sv
tb/tb_top.sv
